[design/bmavg_pkg.sv]
// shared types, widths and constants of the battery moving average block
`default_nettype none

package bmavg_pkg;

    // field and datapath widths
    localparam int PIN_W       = 12;
    localparam int MV_W        = 14;
    localparam int PCT_W       = 7;
    localparam int SUM_W       = 20;
    localparam int DIV_W       = 22;
    localparam int DIV_CNT_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // default window length of the boxcar
    localparam int WINDOW_LEN_DEF = 50;

    // register reset levels
    localparam logic [MV_W-1:0] EMPTY_RST = 14'd3150;
    localparam logic [MV_W-1:0] FULL_RST  = 14'd4200;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL  = 2'd1;

    // x/5 for any 16-bit x: (x * 0xCCCD) >> 18
    localparam logic [15:0] DIV5_RECIP = 16'hCCCD;
    localparam int          DIV5_SHIFT = 18;

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_UPDATE,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_CLAMP,
        S_PCT_GO,
        S_PCT_WAIT,
        S_PUSH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scale;
        logic update;
        logic mean_go;
        logic clamp;
        logic pct_go;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[design/battery_moving_average_percent.sv]
// Battery moving average and percent block. Each pin reading in mV is scaled by the
// 3.2 divider ratio (floor(x*16/5)), placed into a WINDOW_LEN-entry ring with a
// running sum, and yields one result: the rounded window mean and a 0..100 percent
// from the mean clamped to the empty/full levels. One sample is in flight at a time;
// it passes through scaling, ring update, the shared radix-4 divider for the mean,
// clamp, the same divider again for the percent, and the load of the result. The
// next sample is taken in the cycle after the result is loaded, so no new sample is
// accepted while the previous one is still being worked on. A finished result
// sits in an output register, so the next sample is taken while the previous result
// waits; that sample then holds in the load step until the output register frees.
// Ring entries come out of reset as zero through per-entry valid bits, with no
// clearing pass. Level registers may be written only while the block is idle.
`default_nettype none

module battery_moving_average_percent import bmavg_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [MV_W-1:0]         i_cfg_data,
    // sample stream in
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   i_s_axis_tdata,   // [11:0] pin_mv, [15:12] zero
    // result stream out
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_axis_tdata    // [13:0] average_mv,
                                                           // [20:14] charge_percent,
                                                           // [23:21] zero
);

    t_cmd            cmd;
    t_status         status;
    logic [MV_W-1:0] average_mv;
    logic [PCT_W-1:0] charge_percent;

    // level registers accept every transfer
    assign o_cfg_ready = 1'b1;

    bmavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bmavg_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_pin_mv         (i_s_axis_tdata[PIN_W-1:0]),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_average_mv     (average_mv),
        .o_charge_percent (charge_percent)
    );

    // result packing
    assign o_m_axis_tdata = {{(OUT_TDATA_W - MV_W - PCT_W){1'b0}}, charge_percent, average_mv};

endmodule

`default_nettype wire

[design/bmavg_div.sv]
// radix-4 restoring divider, two quotient bits per cycle
`default_nettype none

module bmavg_div import bmavg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_dividend,
    input  wire logic [MV_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic [DIV_W-1:0]       o_quotient
);

    localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_W / 2 - 1);

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [MV_W:0] div_step(input logic [MV_W-1:0] rem,
                                               input logic            bit_in,
                                               input logic [MV_W-1:0] d);
        logic [MV_W:0] t;
        logic [MV_W:0] diff;
        t    = {rem, bit_in};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[MV_W-1:0]};
        end else begin
            return {1'b0, t[MV_W-1:0]};
        end
    endfunction

    logic [MV_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [MV_W-1:0]      r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MV_W:0]        s1, s2;

    // two chained steps, dividend bits shift out as quotient bits shift in
    always_comb begin
        s1    = div_step(r_rem, r_quo[DIV_W-1], r_div);
        s2    = div_step(s1[MV_W-1:0], r_quo[DIV_W-2], r_div);
        n_quo = {r_quo[DIV_W-3:0], s1[MV_W], s2[MV_W]};
        n_rem = s2[MV_W-1:0];
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[design/bmavg_dp.sv]
// datapath: scaling, sample ring, running sum, level registers and result register
`default_nettype none

module bmavg_dp import bmavg_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic [PIN_W-1:0]      i_pin_mv,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [MV_W-1:0]       i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [MV_W-1:0]            o_average_mv,
    output logic [PCT_W-1:0]           o_charge_percent
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0]  HALF_WIN  = SUM_W'(WINDOW_LEN / 2);
    localparam logic [MV_W-1:0]   WIN_DIV   = MV_W'(WINDOW_LEN);

    logic [MV_W-1:0]       r_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] r_vld;
    logic [MV_W-1:0]       r_rd_data;
    logic                  r_rd_vld;
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;
    logic [PIN_W-1:0]      r_pin;
    logic [MV_W-1:0]       r_scaled;
    logic [MV_W-1:0]       r_mean;
    logic [MV_W-1:0]       r_diff;
    logic [MV_W-1:0]       r_empty;
    logic [MV_W-1:0]       r_full;
    logic                  r_out_vld;
    logic [MV_W-1:0]       r_out_avg;
    logic [PCT_W-1:0]      r_out_pct;

    logic [31:0]           scale_prod;
    logic [MV_W-1:0]       old_sample;
    logic [MV_W-1:0]       mean_q;
    logic [MV_W-1:0]       clamped;
    logic                  level_bad;
    logic [DIV_W-1:0]      pct_num;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [MV_W-1:0]       div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;

    // level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= EMPTY_RST;
            r_full  <= FULL_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_EMPTY) begin
                r_empty <= i_cfg_data;
            end else if (i_cfg_index == REG_FULL) begin
                r_full <= i_cfg_data;
            end
        end
    end

    // input capture and divider-ratio scaling by 16/5
    assign scale_prod = 32'({r_pin, 4'b0000}) * 32'(DIV5_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pin <= i_pin_mv;
        end
        if (i_cmd.scale) begin
            r_scaled <= scale_prod[DIV5_SHIFT +: MV_W];
        end
    end

    // sample ring: registered read of the oldest entry, write of the new one
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_rd_data <= r_mem[r_slot];
        end
        if (i_cmd.update) begin
            r_mem[r_slot] <= r_scaled;
        end
    end

    // per-entry valid bits stand in for the cleared ring after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.scale) begin
                r_rd_vld <= r_vld[r_slot];
            end
            if (i_cmd.update) begin
                r_vld[r_slot] <= 1'b1;
            end
        end
    end

    assign old_sample = r_rd_vld ? r_rd_data : '0;

    // running sum and write slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_slot <= '0;
        end else if (i_cmd.update) begin
            r_sum  <= r_sum - SUM_W'(old_sample) + SUM_W'(r_scaled);
            r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
        end
    end

    // clamp of the mean to the level range
    assign mean_q    = div_quo[MV_W-1:0];
    assign level_bad = (r_full <= r_empty);

    always_comb begin
        priority if (mean_q < r_empty) begin
            clamped = r_empty;
        end else if (mean_q > r_full) begin
            clamped = r_full;
        end else begin
            clamped = mean_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_mean <= mean_q;
            r_diff <= clamped - r_empty;
        end
    end

    // shared divider: window mean first, then the percent map
    assign pct_num      = DIV_W'(r_diff) * DIV_W'(PCT_SCALE);
    assign div_start    = i_cmd.mean_go | i_cmd.pct_go;
    assign div_dividend = i_cmd.mean_go ? DIV_W'(r_sum + HALF_WIN) : pct_num;
    assign div_divisor  = i_cmd.mean_go ? WIN_DIV : (r_full - r_empty);

    bmavg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_avg <= r_mean;
            r_out_pct <= level_bad ? '0 : div_quo[PCT_W-1:0];
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid       = r_out_vld;
    assign o_average_mv      = r_out_avg;
    assign o_charge_percent  = r_out_pct;

endmodule

`default_nettype wire

[design/bmavg_ctrl.sv]
// controller state machine sequencing one sample through the datapath
`default_nettype none

module bmavg_ctrl import bmavg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SCALE;
            S_SCALE:     n_state = S_UPDATE;
            S_UPDATE:    n_state = S_MEAN_GO;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: if (i_status.div_done) n_state = S_CLAMP;
            S_CLAMP:     n_state = S_PCT_GO;
            S_PCT_GO:    n_state = S_PCT_WAIT;
            S_PCT_WAIT:  if (i_status.div_done) n_state = S_PUSH;
            S_PUSH:      if (i_status.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_SCALE:     o_cmd.scale    = 1'b1;
            S_UPDATE:    o_cmd.update   = 1'b1;
            S_MEAN_GO:   o_cmd.mean_go  = 1'b1;
            S_MEAN_WAIT: o_cmd          = '0;
            S_CLAMP:     o_cmd.clamp    = 1'b1;
            S_PCT_GO:    o_cmd.pct_go   = 1'b1;
            S_PCT_WAIT:  o_cmd          = '0;
            S_PUSH:      o_cmd.load_out = i_status.out_free;
            default:     o_cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/bmavg_chk.sv]
// port-level checker for the battery moving average block, with its bind
`default_nettype none

module bmavg_chk import bmavg_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // percent never exceeds one hundred
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[MV_W +: PCT_W] <= PCT_SCALE))
        else $error("charge percent above 100");

    // mean of scaled samples stays within the scaled pin range, padding is zero
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[MV_W-1:0] <= 14'd13104) &&
                            (o_m_axis_tdata[OUT_TDATA_W-1:MV_W+PCT_W] == '0))
        else $error("average out of range or nonzero padding");

    // one sample at a time: no new transfer right after one
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after an input transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind battery_moving_average_percent bmavg_chk u_bmavg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
